[hdl/bhpq_pkg.sv]
`default_nettype none
package bhpq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 8;
  localparam int OP_W     = 3;
  localparam int ST_W     = 3;
  localparam int ENTRY_W  = 9;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 3'd1;
  localparam logic [OP_W-1:0] OP_RAISE   = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [ST_W-1:0]         status;
    logic [ENTRY_W-1:0]      entry_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXT_LD,
    S_RAISE_CHK,
    S_ERASE_LD,
    S_READ_LD,
    S_UP_RD,
    S_UP_CMP,
    S_RELOAD,
    S_RELOAD_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_ROOT_LAST,
    RD_POS,
    RD_PARENT,
    RD_CHILDREN
  } rd_mode_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INS_START,
    ACT_EXT_START,
    ACT_ERASE_START,
    ACT_RAISE_START,
    ACT_KEYOUT,
    ACT_RELOAD,
    ACT_WR_CUR,
    ACT_UP_STEP,
    ACT_DN_STEP
  } act_t;

  typedef struct packed {
    logic     latch_in;
    rd_mode_t rd_mode;
    act_t     act;
    logic     set_status;
    status_t  status;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            cnt_empty;
    logic            cnt_full;
    logic            pos_bad;
    logic            key_rej;
    logic            erase_shrink;
    logic            idx_root;
    logic            up_stop;
    logic            dn_stop;
  } sts_t;

endpackage
`default_nettype wire

[hdl/binary_heap_priority_queue_core.sv]
`default_nettype none
// Binary heap priority queue holding up to 256 signed 32-bit keys, with the smallest key at the
// root after reset and the largest key at the root when cfg_data 0 is written. One word in
// gives one word out, and the block works on one word at a time: it takes no new word until
// the last one has reached the output register. Insert and raise sift up, extract sifts down
// and erase may walk up and then down; each tree level walked needs a registered read of the
// heap memory and then a compare-and-write step. A finished word waits in the output register
// while the next word is taken. The heap memory needs no clearing after reset, and the user must
// write the mode register only while the queue is idle; the block itself does not enforce this.
module binary_heap_priority_queue_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bhpq_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bhpq_pkg::out_word_t      out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  bhpq_pkg::cmd_t cmd;
  bhpq_pkg::sts_t sts;
  logic           in_ready;

  assign in_stall  = !in_ready;
  assign cfg_ready = 1'b1;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhpq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.entry_count <= bhpq_pkg::ENTRY_W'(bhpq_pkg::CAPACITY)))
    else $error("entry count beyond capacity");

  a_error_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != bhpq_pkg::ST_OK) |-> (out_word.key_out == '0))
    else $error("nonzero key with error status");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == bhpq_pkg::ST_FULL) |->
      (out_word.entry_count == bhpq_pkg::ENTRY_W'(bhpq_pkg::CAPACITY)))
    else $error("full status while not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == bhpq_pkg::ST_EMPTY) |-> (out_word.entry_count == '0))
    else $error("empty status while not empty");
`endif

endmodule
`default_nettype wire

[hdl/bhpq_dp.sv]
`default_nettype none
module bhpq_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bhpq_pkg::in_word_t in_word,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire bhpq_pkg::cmd_t     cmd,
  output bhpq_pkg::sts_t          sts,
  output bhpq_pkg::out_word_t     out_word
);

  function automatic logic ranks_below(
    input logic signed [bhpq_pkg::KEY_W-1:0] a,
    input logic signed [bhpq_pkg::KEY_W-1:0] b,
    input logic                               min_mode
  );
    ranks_below = min_mode ? (a > b) : (a < b);
  endfunction

  logic signed [bhpq_pkg::KEY_W-1:0] mem [bhpq_pkg::CAPACITY];

  bhpq_pkg::in_word_t                in_r;
  logic                              min_mode_r;
  logic [bhpq_pkg::CNT_W-1:0]        count_r;
  logic [bhpq_pkg::ADDR_W-1:0]       idx_r;
  logic [bhpq_pkg::ADDR_W-1:0]       idx_nxt;
  logic signed [bhpq_pkg::KEY_W-1:0] cur_r;
  logic signed [bhpq_pkg::KEY_W-1:0] rd0_r;
  logic signed [bhpq_pkg::KEY_W-1:0] rd1_r;
  logic signed [bhpq_pkg::KEY_W-1:0] key_out_r;
  bhpq_pkg::status_t                 status_r;
  bhpq_pkg::out_word_t               out_word_r;

  logic [bhpq_pkg::CNT_W-1:0]        count_m1;
  logic [bhpq_pkg::ADDR_W-1:0]       last_a;
  logic [bhpq_pkg::ADDR_W-1:0]       pos_a;
  logic [bhpq_pkg::ADDR_W-1:0]       parent_a;
  logic [bhpq_pkg::CMP_W-1:0]        left_c;
  logic [bhpq_pkg::CMP_W-1:0]        right_c;
  logic [bhpq_pkg::CMP_W-1:0]        count_c;
  logic [bhpq_pkg::CMP_W-1:0]        pos_c;
  logic                              take_l;
  logic                              take_r;
  logic signed [bhpq_pkg::KEY_W-1:0] best_val;
  logic                              up_stop;
  logic                              dn_stop;
  logic [bhpq_pkg::ADDR_W-1:0]       ra0;
  logic [bhpq_pkg::ADDR_W-1:0]       ra1;
  logic                              we;
  logic [bhpq_pkg::ADDR_W-1:0]       waddr;
  logic signed [bhpq_pkg::KEY_W-1:0] wdata;

  assign count_m1 = count_r - bhpq_pkg::CNT_W'(1);
  assign last_a   = count_m1[bhpq_pkg::ADDR_W-1:0];
  assign pos_a    = bhpq_pkg::ADDR_W'(in_r.position);
  assign parent_a = (idx_r - bhpq_pkg::ADDR_W'(1)) >> 1;
  assign left_c   = (bhpq_pkg::CMP_W'(idx_r) << 1) + bhpq_pkg::CMP_W'(1);
  assign right_c  = left_c + bhpq_pkg::CMP_W'(1);
  assign count_c  = bhpq_pkg::CMP_W'(count_r);
  assign pos_c    = bhpq_pkg::CMP_W'(in_r.position);

  assign up_stop  = !ranks_below(rd0_r, cur_r, min_mode_r);
  assign take_l   = (left_c < count_c) && ranks_below(cur_r, rd0_r, min_mode_r);
  assign best_val = take_l ? rd0_r : cur_r;
  assign take_r   = (right_c < count_c) && ranks_below(best_val, rd1_r, min_mode_r);
  assign dn_stop  = !take_l && !take_r;

  always_comb begin
    sts.opcode       = in_r.opcode;
    sts.cnt_empty    = (count_r == '0);
    sts.cnt_full     = (count_r == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY));
    sts.pos_bad      = (pos_c >= count_c);
    sts.key_rej      = ranks_below(in_r.key, rd0_r, min_mode_r);
    sts.erase_shrink = ((pos_c + bhpq_pkg::CMP_W'(1)) < count_c);
    sts.idx_root     = (idx_r == '0);
    sts.up_stop      = up_stop;
    sts.dn_stop      = dn_stop;
  end

  always_comb begin
    ra0 = pos_a;
    ra1 = last_a;
    unique case (cmd.rd_mode)
      bhpq_pkg::RD_ROOT_LAST: begin
        ra0 = '0;
        ra1 = last_a;
      end
      bhpq_pkg::RD_POS: begin
        ra0 = pos_a;
      end
      bhpq_pkg::RD_PARENT: begin
        ra0 = parent_a;
      end
      bhpq_pkg::RD_CHILDREN: begin
        ra0 = left_c[bhpq_pkg::ADDR_W-1:0];
        ra1 = right_c[bhpq_pkg::ADDR_W-1:0];
      end
      default: begin
        ra0 = pos_a;
      end
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = idx_r;
    wdata   = cur_r;
    idx_nxt = idx_r;
    unique case (cmd.act) inside
      bhpq_pkg::ACT_INS_START: begin
        idx_nxt = count_r[bhpq_pkg::ADDR_W-1:0];
      end
      bhpq_pkg::ACT_EXT_START: begin
        idx_nxt = '0;
      end
      bhpq_pkg::ACT_ERASE_START, bhpq_pkg::ACT_RAISE_START, bhpq_pkg::ACT_RELOAD: begin
        idx_nxt = pos_a;
      end
      bhpq_pkg::ACT_WR_CUR: begin
        we = 1'b1;
      end
      bhpq_pkg::ACT_UP_STEP: begin
        we = 1'b1;
        if (!up_stop) begin
          wdata   = rd0_r;
          idx_nxt = parent_a;
        end
      end
      bhpq_pkg::ACT_DN_STEP: begin
        we = 1'b1;
        if (!dn_stop) begin
          wdata   = take_r ? rd1_r : rd0_r;
          idx_nxt = take_r ? right_c[bhpq_pkg::ADDR_W-1:0] : left_c[bhpq_pkg::ADDR_W-1:0];
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mode_r <= 1'b1;
      count_r    <= '0;
    end else begin
      if (cfg_we) begin
        min_mode_r <= cfg_data;
      end
      if (cmd.act == bhpq_pkg::ACT_INS_START) begin
        count_r <= count_r + bhpq_pkg::CNT_W'(1);
      end else if (cmd.act == bhpq_pkg::ACT_EXT_START ||
                   cmd.act == bhpq_pkg::ACT_ERASE_START) begin
        count_r <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch_in) begin
      in_r      <= in_word;
      key_out_r <= '0;
      status_r  <= bhpq_pkg::ST_OK;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    unique case (cmd.act) inside
      bhpq_pkg::ACT_INS_START, bhpq_pkg::ACT_RAISE_START: begin
        cur_r <= in_r.key;
      end
      bhpq_pkg::ACT_EXT_START: begin
        key_out_r <= rd0_r;
        cur_r     <= rd1_r;
      end
      bhpq_pkg::ACT_ERASE_START: begin
        cur_r <= rd1_r;
      end
      bhpq_pkg::ACT_KEYOUT: begin
        key_out_r <= rd0_r;
      end
      bhpq_pkg::ACT_RELOAD: begin
        cur_r <= rd0_r;
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
    if (cmd.load_out) begin
      out_word_r.key_out     <= key_out_r;
      out_word_r.status      <= status_r;
      out_word_r.entry_count <= bhpq_pkg::ENTRY_W'(count_r);
    end
  end

  assign out_word = out_word_r;

endmodule
`default_nettype wire

[hdl/bhpq_ctrl.sv]
`default_nettype none
module bhpq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           out_stall,
  output logic                out_valid,
  input  wire bhpq_pkg::sts_t sts,
  output bhpq_pkg::cmd_t      cmd
);

  bhpq_pkg::state_t state_r;
  bhpq_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  bhpq_pkg::state_t up_exit;

  assign up_exit   = (sts.opcode == bhpq_pkg::OP_ERASE) ? bhpq_pkg::S_RELOAD : bhpq_pkg::S_FINISH;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhpq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      bhpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = bhpq_pkg::S_DECODE;
        end
      end
      bhpq_pkg::S_DECODE: begin
        state_nxt = bhpq_pkg::S_FINISH;
        unique case (sts.opcode)
          bhpq_pkg::OP_INSERT: begin
            if (sts.cnt_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhpq_pkg::ST_FULL;
            end else begin
              cmd.act   = bhpq_pkg::ACT_INS_START;
              state_nxt = bhpq_pkg::S_UP_RD;
            end
          end
          bhpq_pkg::OP_EXTRACT: begin
            if (sts.cnt_empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhpq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_mode = bhpq_pkg::RD_ROOT_LAST;
              state_nxt   = bhpq_pkg::S_EXT_LD;
            end
          end
          bhpq_pkg::OP_RAISE: begin
            if (sts.pos_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhpq_pkg::ST_BADPOS;
            end else begin
              cmd.rd_mode = bhpq_pkg::RD_POS;
              state_nxt   = bhpq_pkg::S_RAISE_CHK;
            end
          end
          bhpq_pkg::OP_ERASE: begin
            if (sts.cnt_empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhpq_pkg::ST_EMPTY;
            end else if (sts.pos_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhpq_pkg::ST_BADPOS;
            end else begin
              cmd.rd_mode = bhpq_pkg::RD_ROOT_LAST;
              state_nxt   = bhpq_pkg::S_ERASE_LD;
            end
          end
          bhpq_pkg::OP_READ: begin
            if (sts.pos_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = bhpq_pkg::ST_BADPOS;
            end else begin
              cmd.rd_mode = bhpq_pkg::RD_POS;
              state_nxt   = bhpq_pkg::S_READ_LD;
            end
          end
          default: begin
            state_nxt = bhpq_pkg::S_FINISH;
          end
        endcase
      end
      bhpq_pkg::S_EXT_LD: begin
        cmd.act   = bhpq_pkg::ACT_EXT_START;
        state_nxt = bhpq_pkg::S_DN_RD;
      end
      bhpq_pkg::S_RAISE_CHK: begin
        if (sts.key_rej) begin
          cmd.set_status = 1'b1;
          cmd.status     = bhpq_pkg::ST_REJECTED;
          state_nxt      = bhpq_pkg::S_FINISH;
        end else begin
          cmd.act   = bhpq_pkg::ACT_RAISE_START;
          state_nxt = bhpq_pkg::S_UP_RD;
        end
      end
      bhpq_pkg::S_ERASE_LD: begin
        cmd.act   = bhpq_pkg::ACT_ERASE_START;
        state_nxt = sts.erase_shrink ? bhpq_pkg::S_UP_RD : bhpq_pkg::S_FINISH;
      end
      bhpq_pkg::S_READ_LD: begin
        cmd.act   = bhpq_pkg::ACT_KEYOUT;
        state_nxt = bhpq_pkg::S_FINISH;
      end
      bhpq_pkg::S_UP_RD: begin
        if (sts.idx_root) begin
          cmd.act   = bhpq_pkg::ACT_WR_CUR;
          state_nxt = up_exit;
        end else begin
          cmd.rd_mode = bhpq_pkg::RD_PARENT;
          state_nxt   = bhpq_pkg::S_UP_CMP;
        end
      end
      bhpq_pkg::S_UP_CMP: begin
        cmd.act   = bhpq_pkg::ACT_UP_STEP;
        state_nxt = sts.up_stop ? up_exit : bhpq_pkg::S_UP_RD;
      end
      bhpq_pkg::S_RELOAD: begin
        cmd.rd_mode = bhpq_pkg::RD_POS;
        state_nxt   = bhpq_pkg::S_RELOAD_LD;
      end
      bhpq_pkg::S_RELOAD_LD: begin
        cmd.act   = bhpq_pkg::ACT_RELOAD;
        state_nxt = bhpq_pkg::S_DN_RD;
      end
      bhpq_pkg::S_DN_RD: begin
        cmd.rd_mode = bhpq_pkg::RD_CHILDREN;
        state_nxt   = bhpq_pkg::S_DN_CMP;
      end
      bhpq_pkg::S_DN_CMP: begin
        cmd.act   = bhpq_pkg::ACT_DN_STEP;
        state_nxt = sts.dn_stop ? bhpq_pkg::S_FINISH : bhpq_pkg::S_DN_RD;
      end
      bhpq_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
